// ===== src/modexp_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// modexp_pkg
// Shared types for the modular exponentiation block: payload structs and the
// command and status bundles between controller and datapath.
// ---------------------------------------------------------------------------
package modexp_pkg;

  localparam int FIELD_W = 32;

  typedef struct packed {
    logic [FIELD_W-1:0] base_value;
    logic [FIELD_W-1:0] exponent_value;
    logic [FIELD_W-1:0] modulus_value;
  } modexp_in_t;

  typedef struct packed {
    logic [FIELD_W-1:0] power_result;
    logic               zero_modulus_error;
  } modexp_out_t;

  // destination of a finished reduction
  typedef enum logic [1:0] {
    TGT_BASE,
    TGT_ACC,
    TGT_SQ
  } modexp_tgt_t;

  typedef struct packed {
    logic        load;
    logic        mul_go;
    logic        mul_sq;
    logic        div_step;
    logic        wr_en;
    modexp_tgt_t tgt;
    logic        out_load;
  } modexp_cmd_t;

  typedef struct packed {
    logic mod_zero;
    logic exp_lsb;
    logic exp_rest_zero;
  } modexp_stat_t;

endpackage

// ===== src/modexp_datapath.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// modexp_datapath
// Operand registers, one WxW multiplier into a product register, and a
// restoring remainder unit that retires one dividend bit per cycle.
// ---------------------------------------------------------------------------
module modexp_datapath #(
  parameter int OPERAND_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  modexp_pkg::modexp_in_t  op,
  input  modexp_pkg::modexp_cmd_t cmd,
  output modexp_pkg::modexp_stat_t stat,
  output modexp_pkg::modexp_out_t  res
);
  import modexp_pkg::*;

  localparam int W = OPERAND_WIDTH;

  logic [W-1:0]   exp_r;
  logic [W-1:0]   mod_r;
  logic [W-1:0]   acc;
  logic [W-1:0]   sq;
  logic [2*W-1:0] prod;
  logic [W-1:0]   rem;
  logic [W-1:0]   mul_a;
  logic [2*W-1:0] prod_next;
  logic [W:0]     rem_shift;
  logic [W:0]     rem_diff;
  logic [W-1:0]   rem_next;

  assign mul_a     = cmd.mul_sq ? sq : acc;
  assign prod_next = mul_a * sq;

  assign rem_shift = {rem, prod[2*W-1]};
  assign rem_diff  = rem_shift - {1'b0, mod_r};
  assign rem_next  = rem_diff[W] ? rem_shift[W-1:0] : rem_diff[W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      exp_r <= op.exponent_value[W-1:0];
      mod_r <= op.modulus_value[W-1:0];
      acc   <= W'(1);
      prod  <= {{W{1'b0}}, op.base_value[W-1:0]};
      rem   <= '0;
    end else if (cmd.mul_go) begin
      prod <= prod_next;
      rem  <= '0;
    end else if (cmd.div_step) begin
      prod <= {prod[2*W-2:0], 1'b0};
      rem  <= rem_next;
    end
    if (cmd.wr_en) begin
      if (cmd.tgt == TGT_ACC) begin
        acc <= rem;
      end else begin
        sq <= rem;
      end
      if (cmd.tgt == TGT_SQ) begin
        exp_r <= {1'b0, exp_r[W-1:1]};
      end
    end
    if (cmd.out_load) begin
      res.power_result       <= stat.mod_zero ? '0 : FIELD_W'(acc);
      res.zero_modulus_error <= stat.mod_zero;
    end
  end

  assign stat.mod_zero      = (mod_r == '0);
  assign stat.exp_lsb       = exp_r[0];
  assign stat.exp_rest_zero = (exp_r[W-1:1] == '0);

  a_acc_reduced: assert property (@(posedge clk) disable iff (rst)
    (cmd.wr_en && cmd.tgt == TGT_ACC) |=> (acc < mod_r))
    else $error("accumulator not reduced");

  a_rem_reduced: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |=> (rem < mod_r))
    else $error("remainder not below modulus");

endmodule

// ===== src/modexp_ctrl.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// modexp_ctrl
// Sequencer for square-and-multiply: issues products, counts remainder
// steps, routes results and owns the output valid.
// ---------------------------------------------------------------------------
module modexp_ctrl #(
  parameter int OPERAND_WIDTH = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    op_valid,
  output logic                    op_ready,
  output logic                    res_valid,
  input  logic                    res_ready,
  input  modexp_pkg::modexp_stat_t stat,
  output modexp_pkg::modexp_cmd_t  cmd
);
  import modexp_pkg::*;

  localparam int DIV_STEPS = 2 * OPERAND_WIDTH;
  localparam int CNT_W     = $clog2(DIV_STEPS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_DIV,
    ST_WRITE,
    ST_CHECK,
    ST_SQUARE,
    ST_FINISH
  } state_t;

  state_t      state;
  state_t      state_next;
  logic [CNT_W-1:0] cnt;
  modexp_tgt_t tgt;
  modexp_tgt_t tgt_next;
  logic        out_fire;

  assign out_fire = (state == ST_FINISH) && (!res_valid || res_ready);
  assign op_ready = (state == ST_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.tgt    = tgt;
    state_next = state;
    tgt_next   = tgt;
    case (state)
      ST_IDLE: begin
        if (op_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_START;
        end
      end
      ST_START: begin
        tgt_next   = TGT_BASE;
        state_next = stat.mod_zero ? ST_FINISH : ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt == CNT_LAST) begin
          state_next = ST_WRITE;
        end
      end
      ST_WRITE: begin
        cmd.wr_en = 1'b1;
        if (tgt == TGT_ACC) begin
          state_next = stat.exp_rest_zero ? ST_FINISH : ST_SQUARE;
        end else begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (stat.exp_lsb) begin
          cmd.mul_go = 1'b1;
          tgt_next   = TGT_ACC;
          state_next = ST_DIV;
        end else if (stat.exp_rest_zero) begin
          state_next = ST_FINISH;
        end else begin
          cmd.mul_go = 1'b1;
          cmd.mul_sq = 1'b1;
          tgt_next   = TGT_SQ;
          state_next = ST_DIV;
        end
      end
      ST_SQUARE: begin
        cmd.mul_go = 1'b1;
        cmd.mul_sq = 1'b1;
        tgt_next   = TGT_SQ;
        state_next = ST_DIV;
      end
      ST_FINISH: begin
        if (out_fire) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      tgt       <= TGT_BASE;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      tgt   <= tgt_next;
      if (state == ST_DIV) begin
        cnt <= cnt + CNT_W'(1);
      end else begin
        cnt <= '0;
      end
      if (out_fire) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  a_rise_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(state == ST_FINISH))
    else $error("result beat raised outside finish");

  a_div_full_length: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WRITE) |-> $past(state == ST_DIV) && $past(cnt == CNT_LAST))
    else $error("write without a full remainder pass");

endmodule

// ===== src/modular_exponentiation.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// modular_exponentiation
// base^exponent mod modulus by right-to-left square-and-multiply, with a
// bit-serial remainder unit shared by all products.
//
//   channel  dir  handshake            beat
//   op       in   op_valid/op_ready    base, exponent, modulus
//   res      out  res_valid/res_ready  power_result, zero_modulus_error
//
// One item at a time. Every modular product, the base reduction included,
// runs as issue, 2W remainder steps, write-back.
// With k significant exponent bits an item needs at most 2*k products.
// A zero exponent needs only the base reduction, a zero modulus none.
// Reset is synchronous; no clearing pass. A held result stalls only the
// finish of the next item; op is taken again right after the result loads.
// ---------------------------------------------------------------------------
module modular_exponentiation #(
  parameter int OPERAND_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   op_valid,
  output logic                   op_ready,
  input  modexp_pkg::modexp_in_t  op,
  output logic                   res_valid,
  input  logic                   res_ready,
  output modexp_pkg::modexp_out_t res
);
  import modexp_pkg::*;

  modexp_cmd_t  cmd;
  modexp_stat_t stat;

  modexp_ctrl #(
    .OPERAND_WIDTH(OPERAND_WIDTH)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .op_valid (op_valid),
    .op_ready (op_ready),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  modexp_datapath #(
    .OPERAND_WIDTH(OPERAND_WIDTH)
  ) u_datapath (
    .clk (clk),
    .rst (rst),
    .op  (op),
    .cmd (cmd),
    .stat(stat),
    .res (res)
  );

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.zero_modulus_error) |-> (res.power_result == '0))
    else $error("error beat with nonzero result");

endmodule

// ===== test/tb_modular_exponentiation.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_modular_exponentiation
// Self-checking bench for the square-and-multiply modular exponentiation
// block. Operand beats are driven on op, and each one is predicted at accept
// time. Result beats on res are compared in order against the predictions.
// Directed corner cases run first, then random traffic under several
// sender and receiver idle patterns.
// ---------------------------------------------------------------------------
module tb_modular_exponentiation;
  import modexp_pkg::*;

  localparam int  OPERAND_W   = 32;
  localparam int  CLK_HALF_NS = 2;
  localparam int  RESET_CYC   = 8;
  localparam int  DRAIN_CYC   = 200;
  localparam int  MAX_REPORTS = 10;
  localparam longint CYCLE_LIMIT = 4000000;

  logic        clk;
  logic        rst;
  logic        op_valid;
  logic        op_ready;
  modexp_in_t  op;
  logic        res_valid;
  logic        res_ready;
  modexp_out_t res;

  modexp_out_t pending_powers[$];
  int          mismatch_count;
  int          send_idle_pct;
  int          recv_stall_pct;
  longint      cycle_count;

  modular_exponentiation #(
    .OPERAND_WIDTH(OPERAND_W)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .op_valid (op_valid),
    .op_ready (op_ready),
    .op       (op),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_HALF_NS) clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  function automatic modexp_out_t predict_power(modexp_in_t item);
    logic [63:0] mask;
    logic [63:0] b;
    logic [63:0] e;
    logic [63:0] m;
    logic [63:0] acc;
    logic [63:0] sq;
    modexp_out_t r;
    mask = (64'd1 << OPERAND_W) - 64'd1;
    b = {32'd0, item.base_value} & mask;
    e = {32'd0, item.exponent_value} & mask;
    m = {32'd0, item.modulus_value} & mask;
    if (m == 64'd0) begin
      r.power_result       = '0;
      r.zero_modulus_error = 1'b1;
    end else begin
      acc = 64'd1;
      sq  = b % m;
      for (int i = 0; i < OPERAND_W; i++) begin
        if (e[i]) acc = (acc * sq) % m;
        sq = (sq * sq) % m;
      end
      r.power_result       = acc[31:0];
      r.zero_modulus_error = 1'b0;
    end
    return r;
  endfunction

  // one operand beat; valid stays up across back-to-back beats
  task automatic send_op(input logic [31:0] b, input logic [31:0] e,
                         input logic [31:0] m);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      op_valid = 1'b0;
      op       = {$urandom, $urandom, $urandom};
      @(negedge clk);
    end
    op_valid          = 1'b1;
    op.base_value     = b;
    op.exponent_value = e;
    op.modulus_value  = m;
    do @(posedge clk); while (!op_ready);
    pending_powers.push_back(predict_power(op));
  endtask

  task automatic end_traffic();
    @(negedge clk);
    op_valid = 1'b0;
  endtask

  // result checker and receiver stall driver
  initial begin
    modexp_out_t want;
    forever begin
      @(posedge clk);
      if (!rst && res_valid && res_ready) begin
        if (pending_powers.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("unexpected result beat: power=%h err=%b",
                     res.power_result, res.zero_modulus_error);
        end else begin
          want = pending_powers.pop_front();
          if (res.power_result !== want.power_result ||
              res.zero_modulus_error !== want.zero_modulus_error) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
              $display("mismatch: expected power=%h err=%b, got power=%h err=%b",
                       want.power_result, want.zero_modulus_error,
                       res.power_result, res.zero_modulus_error);
          end
        end
      end
      @(negedge clk);
      res_ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(9))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'd1;
      3, 4:    return $urandom_range(2, 1000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_exponent();
    case ($urandom_range(7))
      0, 1:    return $urandom;
      2:       return 32'd0;
      default: return $urandom_range(1, 255);
    endcase
  endfunction

  task automatic test_zero_modulus();
    send_op(32'd5, 32'd3, 32'd0);
    send_op(32'd0, 32'd0, 32'd0);
    send_op(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
  endtask

  task automatic test_zero_exponent();
    send_op(32'd7, 32'd0, 32'd1);
    send_op(32'd0, 32'd0, 32'd13);
    send_op(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
  endtask

  task automatic test_zero_base();
    send_op(32'd0, 32'd5, 32'd7);
    send_op(32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
  endtask

  task automatic test_extremes();
    send_op(32'd5, 32'd3, 32'd1);
    send_op(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_op(32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFE);
    send_op(32'hFFFF_FFFE, 32'd2, 32'hFFFF_FFFF);
    send_op(32'h8000_0000, 32'd2, 32'hFFFF_FFFB);
    send_op(32'd2, 32'd31, 32'hFFFF_FFFF);
    send_op(32'd3, 32'h8000_0000, 32'hFFFF_FFFB);
    send_op(32'd1, 32'hFFFF_FFFF, 32'd2);
    send_op(32'd123456789, 32'hAAAA_5555, 32'd1000000007);
    send_op(32'd10, 32'd3, 32'd7);
    send_op(32'd1, 32'd1, 32'hFFFF_FFFF);
    end_traffic();
  endtask

  task automatic test_random_traffic(input int n, input int idle_pct,
                                     input int stall_pct);
    logic [31:0] m;
    wait (pending_powers.size() == 0);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < n; i++) begin
      m = ($urandom_range(15) == 0) ? rand_operand() : $urandom;
      send_op(rand_operand(), rand_exponent(), m);
    end
    end_traffic();
  endtask

  initial begin
    rst            = 1'b1;
    op_valid       = 1'b0;
    op             = '0;
    res_ready      = 1'b0;
    mismatch_count = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (RESET_CYC) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_zero_modulus();
    test_zero_exponent();
    test_zero_base();
    test_extremes();
    test_random_traffic(30, 0, 0);
    test_random_traffic(30, 59, 0);
    test_random_traffic(30, 0, 59);
    test_random_traffic(30, 37, 37);

    wait (pending_powers.size() == 0);
    repeat (DRAIN_CYC) @(posedge clk);
    if (mismatch_count == 0 && pending_powers.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== modular_exponentiation.f =====
src/modexp_pkg.sv
src/modexp_datapath.sv
src/modexp_ctrl.sv
src/modular_exponentiation.sv
test/tb_modular_exponentiation.sv
